// File: rtl/core/aof_pkg.sv
// Shared constants, register codes and transaction structs of the alpha outline filter.
// Depends on nothing; every other file of the block but aof_ram imports it.
package aof_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 32;
    localparam int ALPHA_W = 8;
    localparam int GEOM_W  = 11;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int QW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
    localparam int AW    = $clog2(2 * MAX_WIDTH);
    localparam int CNT_W = $clog2(QW + 1);

    localparam int RAM_DEPTH = 2 ** AW;

    localparam int NB_W  = 3;
    localparam int NB_L  = 0;
    localparam int NB_C  = 1;
    localparam int NB_R  = 2;
    localparam int MID_W = PIX_W + NB_W;

    localparam int RST_WIDTH  = (16 > MAX_WIDTH) ? MAX_WIDTH : 16;
    localparam int RST_HEIGHT = (32 > MAX_HEIGHT) ? MAX_HEIGHT : 32;
    localparam int RST_TOTAL  = RST_WIDTH * RST_HEIGHT;
    localparam logic [PIX_W-1:0] RST_COLOR = 32'hFF00_00FF;

    typedef enum logic [CIDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COLOR  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [WW-1:0]    width;
        logic [HW-1:0]    height;
        logic [QW-1:0]    total;
        logic [QW-1:0]    total_w;
        logic [PIX_W-1:0] color;
    } geom_t;

    typedef struct packed {
        logic          valid;
        logic [WW-1:0] value;
    } rem_t;

    typedef struct packed {
        logic            has_result;
        logic            frame_last;
        logic            row_first;
        logic            row_last;
        logic            col_first;
        logic            col_last;
        logic [NB_W-1:0] below;
    } item_ctl_t;

endpackage

// File: rtl/core/alpha_outline_filter_unit.sv
// Top level of the alpha outline filter: ties the configuration block, input stage,
// row memories and neighborhood stage together. Depends on aof_pkg and all aof_* modules.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_pixel_in[31:0], s_drain
//  m_        out        m_valid / m_ready    m_pixel_out[31:0], m_frame_last
//  cfg_      in         cfg_we (no wait)     cfg_index[1:0], cfg_wdata[31:0]
//
// One transaction is accepted per cycle while s_ready is high; its result reaches m_
// through the registered row memory read and the output register.
// A write to image_width or image_height holds s_ready low while a serial remainder
// unit rebuilds the column position.
// Reset clears counters and valid flags; row memories are not cleared and need no sweep.
// A stalled m_ holds one result in the output register and one in the window stage.
module alpha_outline_filter_unit import aof_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [PIX_W-1:0]  s_pixel_in,
    input  logic              s_drain,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_pixel_out,
    output logic              m_frame_last,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    geom_t            geom;
    rem_t             col_load;
    item_ctl_t        ctl;
    logic             busy, b_free, accept;
    logic [QW-1:0]    item_count;
    logic [AW-1:0]    wr_addr, mid_addr, top_addr;
    logic [MID_W-1:0] mid_wdata, mid_rdata;
    logic [NB_W-1:0]  top_wdata, top_rdata;

    assign s_ready = !busy && b_free;
    assign accept  = s_valid && s_ready;

    aof_geom u_geom (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_count (item_count),
        .geom       (geom),
        .busy       (busy),
        .col_load   (col_load)
    );

    aof_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .s_pixel_in (s_pixel_in),
        .s_drain    (s_drain),
        .geom       (geom),
        .col_load   (col_load),
        .item_count (item_count),
        .wr_addr    (wr_addr),
        .mid_addr   (mid_addr),
        .top_addr   (top_addr),
        .mid_wdata  (mid_wdata),
        .top_wdata  (top_wdata),
        .ctl        (ctl)
    );

    aof_ram #(
        .WIDTH (MID_W),
        .DEPTH (RAM_DEPTH)
    ) u_mid_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wr_addr),
        .wdata (mid_wdata),
        .re    (accept),
        .raddr (mid_addr),
        .rdata (mid_rdata)
    );

    aof_ram #(
        .WIDTH (NB_W),
        .DEPTH (RAM_DEPTH)
    ) u_top_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wr_addr),
        .wdata (top_wdata),
        .re    (accept),
        .raddr (top_addr),
        .rdata (top_rdata)
    );

    aof_window u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .ctl          (ctl),
        .mid_rdata    (mid_rdata),
        .top_rdata    (top_rdata),
        .color        (geom.color),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_pixel_out  (m_pixel_out),
        .m_frame_last (m_frame_last),
        .b_free       (b_free)
    );

endmodule

// File: rtl/core/aof_ram.sv
// Generic single-write, single-read memory with a registered, read-first output.
// Depends on nothing.
module aof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/aof_geom.sv
// Configuration registers, derived frame sizes and the serial remainder unit that
// rebuilds the column position after a geometry write. Depends on aof_pkg.
module aof_geom import aof_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [QW-1:0]     item_count,
    output geom_t             geom,
    output logic              busy,
    output rem_t              col_load
);

    function automatic logic [WW-1:0] clamp_width(input logic [GEOM_W-1:0] raw);
        logic [WW-1:0] res;
        if (raw == '0) begin
            res = WW'(1);
        end else if (32'(raw) > 32'(MAX_WIDTH)) begin
            res = WW'(MAX_WIDTH);
        end else begin
            res = WW'(raw);
        end
        return res;
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [GEOM_W-1:0] raw);
        logic [HW-1:0] res;
        if (raw == '0) begin
            res = HW'(1);
        end else if (32'(raw) > 32'(MAX_HEIGHT)) begin
            res = HW'(MAX_HEIGHT);
        end else begin
            res = HW'(raw);
        end
        return res;
    endfunction

    logic [WW-1:0]    width_reg, width_next;
    logic [HW-1:0]    height_reg, height_next;
    logic [PIX_W-1:0] color_reg, color_next;
    logic [QW-1:0]    total_reg, total_next;
    logic [QW-1:0]    total_w_reg, total_w_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]    dividend_reg, dividend_next;
    logic [WW-1:0]    rem_reg, rem_next;

    logic [WW+HW-1:0] width_ext, height_ext, prod;
    logic [WW:0]      trial, divisor;

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        color_next    = color_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;

        width_ext    = (WW+HW)'(width_reg);
        height_ext   = (WW+HW)'(height_reg);
        prod         = width_ext * height_ext;
        total_next   = QW'(prod);
        total_w_next = total_reg + QW'(width_reg);

        // One quotient bit per cycle, most significant bit of the count first.
        trial   = {rem_reg, dividend_reg[QW-1]};
        divisor = {1'b0, width_reg};
        if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                rem_next      = (trial >= divisor) ? WW'(trial - divisor) : WW'(trial);
                dividend_next = dividend_reg << 1;
                cnt_next      = cnt_reg - 1'b1;
            end
        end

        if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH: begin
                    width_next    = clamp_width(cfg_wdata[GEOM_W-1:0]);
                    busy_next     = 1'b1;
                    cnt_next      = CNT_W'(QW);
                    dividend_next = item_count;
                    rem_next      = '0;
                end
                REG_HEIGHT: begin
                    height_next   = clamp_height(cfg_wdata[GEOM_W-1:0]);
                    busy_next     = 1'b1;
                    cnt_next      = CNT_W'(QW);
                    dividend_next = item_count;
                    rem_next      = '0;
                end
                REG_COLOR: begin
                    color_next = cfg_wdata[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WW'(RST_WIDTH);
            height_reg  <= HW'(RST_HEIGHT);
            color_reg   <= RST_COLOR;
            total_reg   <= QW'(RST_TOTAL);
            total_w_reg <= QW'(RST_TOTAL + RST_WIDTH);
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            color_reg   <= color_next;
            total_reg   <= total_next;
            total_w_reg <= total_w_next;
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
    end

    always_comb begin
        geom.width     = width_reg;
        geom.height    = height_reg;
        geom.total     = total_reg;
        geom.total_w   = total_w_reg;
        geom.color     = color_reg;
        busy           = busy_reg;
        col_load.valid = busy_reg && (cnt_reg == '0);
        col_load.value = rem_reg;
    end

endmodule

// File: rtl/core/aof_scan.sv
// Input stage: item and column counters, neighbor flag history, row memory write
// data and read addresses, and the per-transaction control word. Depends on aof_pkg.
module aof_scan import aof_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [PIX_W-1:0] s_pixel_in,
    input  logic             s_drain,
    input  geom_t            geom,
    input  rem_t             col_load,
    output logic [QW-1:0]    item_count,
    output logic [AW-1:0]    wr_addr,
    output logic [AW-1:0]    mid_addr,
    output logic [AW-1:0]    top_addr,
    output logic [MID_W-1:0] mid_wdata,
    output logic [NB_W-1:0]  top_wdata,
    output item_ctl_t        ctl
);

    logic [QW-1:0]    count_reg, count_next;
    logic [WW-1:0]    col_reg, col_next;
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [PIX_W-1:0] prev_pix_reg;
    logic [1:0]       hist_reg;

    logic [PIX_W-1:0] store_pix;
    logic             flag;
    logic [NB_W-1:0]  nb_now;
    logic             after, over, at_end, restart;
    logic [WW-1:0]    col_inc;

    always_comb begin
        after  = count_reg > QW'(geom.width);
        over   = count_reg > geom.total_w;
        at_end = count_reg == geom.total_w;

        // A drain transaction, or anything past the last pixel, stores a clear pixel.
        store_pix = ((count_reg < geom.total) && !s_drain) ? s_pixel_in : '0;
        flag      = |store_pix[ALPHA_W-1:0];
        nb_now    = {flag, hist_reg[0], hist_reg[1]};

        ctl.has_result = after && !over;
        ctl.frame_last = at_end;
        ctl.row_first  = count_reg <= QW'({geom.width, 1'b0});
        ctl.row_last   = count_reg > geom.total;
        ctl.col_first  = (col_reg == WW'(1)) || (geom.width == WW'(1));
        ctl.col_last   = col_reg == '0;
        ctl.below      = nb_now;

        restart = after && (over || at_end);
        col_inc = col_reg + 1'b1;

        count_next = count_reg;
        col_next   = col_reg;
        wptr_next  = wptr_reg;
        if (accept) begin
            count_next = restart ? '0 : count_reg + 1'b1;
            col_next   = (restart || (col_inc == geom.width)) ? '0 : col_inc;
            wptr_next  = wptr_reg + 1'b1;
        end else if (col_load.valid) begin
            col_next = col_load.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            col_reg   <= '0;
            wptr_reg  <= '0;
        end else begin
            count_reg <= count_next;
            col_reg   <= col_next;
            wptr_reg  <= wptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_pix_reg <= store_pix;
            hist_reg     <= {hist_reg[0], flag};
        end
    end

    assign item_count = count_reg;
    assign wr_addr    = wptr_reg;
    assign mid_addr   = wptr_reg - AW'(geom.width);
    assign top_addr   = wptr_reg - AW'({geom.width, 1'b0});
    assign mid_wdata  = {prev_pix_reg, nb_now};
    assign top_wdata  = nb_now;

endmodule

// File: rtl/core/aof_window.sv
// Neighborhood stage: masks the 3x3 opacity window at the image borders, picks the
// outline color or the source pixel, and holds the output register. Depends on aof_pkg.
module aof_window import aof_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  item_ctl_t        ctl,
    input  logic [MID_W-1:0] mid_rdata,
    input  logic [NB_W-1:0]  top_rdata,
    input  logic [PIX_W-1:0] color,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [PIX_W-1:0] m_pixel_out,
    output logic             m_frame_last,
    output logic             b_free
);

    logic             b_valid_reg, b_valid_next;
    logic             m_valid_reg, m_valid_next;
    item_ctl_t        b_ctl_reg;
    logic [PIX_W-1:0] m_pixel_reg;
    logic             m_last_reg;

    logic             out_free, b_move;
    logic [PIX_W-1:0] center;
    logic [NB_W-1:0]  mid, top, low;
    logic             hit_top, hit_mid, hit_low, outline;
    logic [PIX_W-1:0] pixel_next;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        b_move   = b_valid_reg && out_free;
        b_free   = !b_valid_reg || out_free;

        center = mid_rdata[MID_W-1:NB_W];
        mid    = mid_rdata[NB_W-1:0];
        top    = top_rdata;
        low    = b_ctl_reg.below;

        hit_top = !b_ctl_reg.row_first && (top[NB_C]
                  || (!b_ctl_reg.col_first && top[NB_L])
                  || (!b_ctl_reg.col_last && top[NB_R]));
        hit_mid = (!b_ctl_reg.col_first && mid[NB_L])
                  || (!b_ctl_reg.col_last && mid[NB_R]);
        hit_low = !b_ctl_reg.row_last && (low[NB_C]
                  || (!b_ctl_reg.col_first && low[NB_L])
                  || (!b_ctl_reg.col_last && low[NB_R]));
        outline    = !mid[NB_C] && (hit_top || hit_mid || hit_low);
        pixel_next = outline ? color : center;

        if (accept) begin
            b_valid_next = ctl.has_result;
        end else if (b_move) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end

        if (b_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_ctl_reg <= ctl;
        end
        if (b_move) begin
            m_pixel_reg <= pixel_next;
            m_last_reg  <= b_ctl_reg.frame_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

endmodule

// File: rtl/core/aof_checker.sv
// Port-level assertions for the alpha outline filter and the bind that attaches them.
// Depends on aof_pkg and on the port names of alpha_outline_filter_unit.
module aof_checker import aof_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [PIX_W-1:0]  m_pixel_out,
    input logic              m_frame_last,
    input logic              cfg_we,
    input logic [CIDX_W-1:0] cfg_index
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out) && $stable(m_frame_last))
        else $error("result transaction changed while stalled");

    // A geometry write blocks input while the column position is rebuilt.
    a_geom_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) |=> !s_ready)
        else $error("input accepted right after a geometry write");

    // A result from an empty output register comes from an input transaction that passed the window stage with no wait.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result transaction without a matching input transaction");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind alpha_outline_filter_unit aof_checker u_aof_checker (.*);

// File: sim/alpha_outline_filter_unit_checker.sv
// Checker for the alpha outline filter: watches the s_, m_ and cfg_ ports, predicts every
// result pixel of the 3x3 alpha outline and compares it with what the block delivers.
// Depends on aof_pkg for widths and register codes.
module alpha_outline_filter_unit_checker import aof_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [PIX_W-1:0]  s_pixel_in,
    input  logic              s_drain,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [PIX_W-1:0]  m_pixel_out,
    input  logic              m_frame_last,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output int                error_count,
    output int                pending_count,
    output int                result_count,
    output int                outline_count
);

    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } outline_result_t;

    logic [GEOM_W-1:0] width_reg;
    logic [GEOM_W-1:0] height_reg;
    logic [PIX_W-1:0]  color_reg;
    logic [PIX_W-1:0]  pixel_history [HIST_DEPTH];
    int unsigned       frame_position;
    outline_result_t   outline_pixels_due [$];
    int                errors_seen;
    int                results_seen;
    int                outlines_seen;

    function automatic int unsigned clamp_dim(input logic [GEOM_W-1:0] v, input int unsigned lim);
        if (v == '0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    task automatic compute_outline_pixel(input logic [PIX_W-1:0] pix, input logic drn);
        int unsigned     w;
        int unsigned     h;
        int unsigned     total;
        int unsigned     q;
        int unsigned     p;
        int unsigned     row;
        int unsigned     col;
        int unsigned     k;
        int              dr;
        int              dc;
        logic [PIX_W-1:0] center;
        bit              lit;
        outline_result_t res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        q = frame_position;
        pixel_history[q % HIST_DEPTH] = (q < total && !drn) ? pix : '0;
        frame_position = q + 1;
        if (q >= w + 1) begin
            p = q - w - 1;
            if (p >= total) begin
                frame_position = 0;
            end else begin
                row = p / w;
                col = p % w;
                center = pixel_history[p % HIST_DEPTH];
                lit = 1'b0;
                if (center[ALPHA_W-1:0] == '0) begin
                    for (dr = -1; dr <= 1; dr++) begin
                        for (dc = -1; dc <= 1; dc++) begin
                            if ((dr != 0 || dc != 0) && !(dr < 0 && row == 0) &&
                                !(dr > 0 && row + 1 >= h) && !(dc < 0 && col == 0) &&
                                !(dc > 0 && col + 1 >= w)) begin
                                k = p;
                                if (dr < 0) k -= w;
                                if (dr > 0) k += w;
                                if (dc < 0) k -= 1;
                                if (dc > 0) k += 1;
                                if (pixel_history[k % HIST_DEPTH][ALPHA_W-1:0] != '0)
                                    lit = 1'b1;
                            end
                        end
                    end
                end
                res.pixel = lit ? color_reg : center;
                res.last = (p == total - 1);
                if (res.last)
                    frame_position = 0;
                if (lit)
                    outlines_seen++;
                outline_pixels_due.insert(outline_pixels_due.size(), res);
            end
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        outline_result_t due;
        if (!aresetn) begin
            width_reg = GEOM_W'(RST_WIDTH);
            height_reg = GEOM_W'(RST_HEIGHT);
            color_reg = RST_COLOR;
            frame_position = 0;
            for (int i = 0; i < HIST_DEPTH; i++)
                pixel_history[i] = '0;
            outline_pixels_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (outline_pixels_due.size() == 0) begin
                    errors_seen++;
                    $display("%0t: result %h (frame_last %b) arrived with no pixel due",
                             $time, m_pixel_out, m_frame_last);
                end else begin
                    due = outline_pixels_due.pop_front();
                    results_seen++;
                    if (m_pixel_out !== due.pixel) begin
                        errors_seen++;
                        $display("%0t: pixel_out expected %h, got %h",
                                 $time, due.pixel, m_pixel_out);
                    end
                    if (m_frame_last !== due.last) begin
                        errors_seen++;
                        $display("%0t: frame_last expected %b, got %b",
                                 $time, due.last, m_frame_last);
                    end
                end
            end
            if (s_valid && s_ready)
                compute_outline_pixel(s_pixel_in, s_drain);
            if (cfg_we) begin
                case (cfg_index)
                    REG_WIDTH:  width_reg = cfg_wdata[GEOM_W-1:0];
                    REG_HEIGHT: height_reg = cfg_wdata[GEOM_W-1:0];
                    REG_COLOR:  color_reg = cfg_wdata[PIX_W-1:0];
                    default:    ;
                endcase
            end
        end
        error_count <= errors_seen;
        pending_count <= outline_pixels_due.size();
        result_count <= results_seen;
        outline_count <= outlines_seen;
    end

endmodule

// File: sim/alpha_outline_filter_unit_test.sv
// Top of the alpha outline filter testbench: clock, reset, register writes and pixel
// stimulus; checking is done by alpha_outline_filter_unit_checker. Depends on aof_pkg.
module alpha_outline_filter_unit_test;
    import aof_pkg::*;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 500;
    localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [PIX_W-1:0]  s_pixel_in = '0;
    logic              s_drain = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PIX_W-1:0]  m_pixel_out;
    logic              m_frame_last;
    logic              cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    int          error_count;
    int          pending_count;
    int          result_count;
    int          outline_count;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          sent_count = 0;
    int          frames_sent = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_request = 1'b0;
    int unsigned geom_w = RST_WIDTH;
    int unsigned geom_h = RST_HEIGHT;

    alpha_outline_filter_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .s_drain      (s_drain),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_frame_last (m_frame_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    alpha_outline_filter_unit_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_drain       (s_drain),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_frame_last  (m_frame_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .outline_count (outline_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d pixels still due", cycle_count,
                     pending_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic int unsigned usable_dim(input logic [GEOM_W-1:0] v, input int unsigned lim);
        if (v == '0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    function automatic logic [PIX_W-1:0] glyph_pixel(input int opaque_pct);
        logic [PIX_W-1:0] v;
        v = $urandom;
        if ($urandom_range(99) >= opaque_pct)
            v[ALPHA_W-1:0] = '0;
        return v;
    endfunction

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == REG_WIDTH)
            geom_w = usable_dim(data[GEOM_W-1:0], MAX_WIDTH);
        if (idx == REG_HEIGHT)
            geom_h = usable_dim(data[GEOM_W-1:0], MAX_HEIGHT);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(input logic [PIX_W-1:0] pix, input logic drn);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_in <= pix;
        s_drain <= drn;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic send_frame(input bit broken, input int opaque_pct);
        int n_tail;
        n_tail = geom_w + 1;
        for (int i = 0; i < geom_w * geom_h; i++) begin
            if (broken && $urandom_range(5) == 0)
                send_item($urandom, 1'b1);
            else
                send_item(glyph_pixel(opaque_pct), 1'b0);
        end
        if (broken && $urandom_range(2) == 0)
            n_tail = $urandom_range(0, geom_w);
        for (int i = 0; i < n_tail; i++) begin
            if (broken && $urandom_range(2) == 0)
                send_item($urandom, 1'b0);
            else
                send_item($urandom, 1'b1);
        end
        frames_sent++;
    endtask

    task automatic write_geometry(input int unsigned w, input int unsigned h);
        logic [CFG_W-1:0] data;
        data = w;
        if ($urandom_range(3) == 0)
            data[CFG_W-1:GEOM_W] = (CFG_W-GEOM_W)'($urandom);
        write_reg(REG_WIDTH, data);
        data = h;
        if ($urandom_range(3) == 0)
            data[CFG_W-1:GEOM_W] = (CFG_W-GEOM_W)'($urandom);
        write_reg(REG_HEIGHT, data);
    endtask

    task automatic run_phase(input int g, input int st, input bit squeeze);
        int target;
        int unsigned w;
        int unsigned h;
        gap_pct = g;
        stall_pct = st;
        target = sent_count + RANDOM_ITEMS / 5;
        while (sent_count < target) begin
            settle();
            if ($urandom_range(3) == 0) begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 3);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            if (squeeze) begin
                w = 8;
                h = 6;
            end
            write_geometry(w, h);
            write_reg(REG_COLOR, $urandom);
            if ($urandom_range(4) == 0)
                write_reg(REG_SPARE, $urandom);
            repeat ($urandom_range(1, 3)) begin
                if (squeeze) begin
                    hold_request = 1'b1;
                    squeeze = 1'b0;
                end
                send_frame($urandom_range(4) == 0, $urandom_range(10, 70));
                if ($urandom_range(7) == 0)
                    settle();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Small frame under the reset color, with a drain inside the frame and a pixel
        // transaction standing in for the last drain.
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        send_item(32'hFFFF_FF00, 1'b0);
        send_item(32'h1234_5601, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hABCD_EF80, 1'b1);
        send_item(32'h8080_8000, 1'b0);
        send_item($urandom, 1'b1);
        send_item($urandom, 1'b1);
        send_item($urandom, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b0);

        // Zero geometry is taken as a single pixel.
        settle();
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_COLOR, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FF00, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h0000_0000, 1'b1);

        // Geometry shrinks in mid frame so the next position lies past the frame end.
        settle();
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        write_reg(REG_COLOR, 32'h0000_0000);
        send_item(32'hFFFF_FF00, 1'b0);
        send_item(32'h1111_11FF, 1'b0);
        send_item(32'h2222_2200, 1'b0);
        send_item(32'h3333_3300, 1'b0);
        send_item(32'h4444_4444, 1'b0);
        settle();
        write_reg(REG_WIDTH, 32'hFFFF_F801);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_SPARE, $urandom);
        send_item(32'h5555_5501, 1'b0);
        send_item(32'h8080_8080, 1'b0);
        send_item($urandom, 1'b1);
        send_item($urandom, 1'b1);

        run_phase(0, 0, 1'b1);
        run_phase(61, 0, 1'b0);
        run_phase(0, 61, 1'b0);
        run_phase(12, 12, 1'b0);

        // Oversized geometry saturates, then a shrink in mid frame ends the frame.
        gap_pct = 0;
        stall_pct = 12;
        settle();
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 2047);
        write_reg(REG_COLOR, $urandom);
        repeat (6) send_item(glyph_pixel(40), 1'b0);
        settle();
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 2);
        send_item($urandom, 1'b1);
        settle();

        $display("Covered %0d input transactions in %0d frames, with broken frames,",
                 sent_count, frames_sent);
        $display("geometry changes in mid frame and saturated sizes; checked %0d pixels,",
                 result_count);
        $display("%0d of them outline pixels, with %0d mismatches.",
                 outline_count, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
